// File: hw/rtl/hpf_pkg.sv
package hpf_pkg;

   // Sizing of the block
   localparam int NUM_BINS  = 128;
   localparam int BIN_SCALE = 4;
   localparam int MAX_PEAKS = 6;

   // Field widths
   localparam int COLOUR_W = 4;
   localparam int VAL_W    = 10;
   localparam int DIV_W    = 5;
   localparam int POS_W    = 10;
   localparam int TOT_W    = 3;

   localparam int POS_MAX = 1023;
   localparam int TOT_MAX = 7;

   // Derived widths
   localparam int BIN_W     = $clog2(NUM_BINS);
   localparam int CNT_W     = $clog2(NUM_BINS + 1);
   localparam int PC_W      = $clog2(MAX_PEAKS + 1);
   localparam int PL_IDX_W  = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
   localparam int PCX_W     = PC_W + TOT_W;
   localparam int SCALE_W   = $clog2(BIN_SCALE + 1);
   localparam int PROD_W    = (CNT_W + SCALE_W > POS_W) ? CNT_W + SCALE_W : POS_W + 1;
   localparam int STEP_W    = $clog2(VAL_W + 1);

   // Stream and register port widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLOUR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVISOR = 2'd2;

   localparam logic [DIV_W-1:0] DIVISOR_RESET = 5'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIN,
      ST_PEAK,
      ST_CUT,
      ST_RCHK,
      ST_RCMP,
      ST_LCHK,
      ST_LCMP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [VAL_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [VAL_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: hw/rtl/hpf_ram.sv
module hpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/hpf_div.sv
module hpf_div (
   input  logic                clock,
   input  logic                reset,
   input  hpf_pkg::div_req_type div_req,
   output hpf_pkg::div_rsp_type div_rsp
);

   logic [hpf_pkg::VAL_W-1:0]  dvd_ff, dvd_in;
   logic [hpf_pkg::DIV_W-1:0]  rem_ff, rem_in;
   logic [hpf_pkg::DIV_W-1:0]  dsr_ff, dsr_in;
   logic [hpf_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [hpf_pkg::DIV_W:0]    trial;
   logic [hpf_pkg::DIV_W:0]    diff;
   logic                       ge;

   // One quotient bit per cycle, restoring form
   always_comb begin
      trial   = {rem_ff, dvd_ff[hpf_pkg::VAL_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      ge      = (trial >= {1'b0, dsr_ff});
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         dvd_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[hpf_pkg::DIV_W-1:0] : trial[hpf_pkg::DIV_W-1:0];
         dvd_in  = {dvd_ff[hpf_pkg::VAL_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == hpf_pkg::STEP_W'(hpf_pkg::VAL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule

// File: hw/rtl/histogram_peak_finder_unit.sv
// Histogram peak finder.
// req channel: one histogram bin per transfer. tuser carries the bin's colour,
// tdata the bin count, tlast marks the final bin of the histogram. Bins of the
// colour set in the colour register are stored in a 128-entry bin memory and a
// running peak is tracked; other colours only count for their tlast.
// A bin waits on the divider when an open peak has to be compared with its
// closing level: that level comes from a 10-step serial divider.
// rsp channel: nothing until the final bin. Then one transfer per peak found
// (or one transfer with peak_found clear if none), tlast on the last of them.
// Each peak is refined by walking the bin memory right and left from the peak
// bin, each bin visited being a registered memory read, then a compare; a side
// also stops at the end of the loaded bins. With a full peak list the raw
// indices go out in place of refined positions.
// The block takes no new bin while loading a compare or emitting peaks.
// rsp holds in an output register; a stalled receiver stops the peak walk at
// the next result but a new histogram may start while the final result waits.
// Reset (synchronous, active high) clears the tracking state and registers;
// the bin memory needs no clearing pass. csr writes land on the clock edge.
module histogram_peak_finder_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [hpf_pkg::REQ_DATA_W-1:0]   req_tdata,   // bin_count
   input  logic [hpf_pkg::COLOUR_W-1:0]     req_tuser,   // bin_colour
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [hpf_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // peak_position, peak_total
   output logic [hpf_pkg::RSP_USER_W-1:0]   rsp_tuser,   // peak_found, list_full
   output logic                             rsp_tlast,
   input  logic                             csr_wr_en,
   input  logic [hpf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hpf_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   hpf_pkg::state_type state_ff, state_in;

   logic [hpf_pkg::COLOUR_W-1:0] colour_sel_ff, colour_sel_in;
   logic [hpf_pkg::VAL_W-1:0]    floor_ff, floor_in;
   logic [hpf_pkg::DIV_W-1:0]    divcfg_ff, divcfg_in;

   logic [hpf_pkg::VAL_W-1:0]    rp_ff, rp_in;
   logic [hpf_pkg::BIN_W-1:0]    rpbin_ff, rpbin_in;
   logic                         open_ff, open_in;
   logic [hpf_pkg::VAL_W-1:0]    min_ff, min_in;
   logic [hpf_pkg::PC_W-1:0]     pc_ff, pc_in;
   logic [hpf_pkg::CNT_W-1:0]    bincnt_ff, bincnt_in;
   logic [hpf_pkg::BIN_W-1:0]    peak_list_ff [hpf_pkg::MAX_PEAKS];
   logic [hpf_pkg::BIN_W-1:0]    peak_list_in [hpf_pkg::MAX_PEAKS];

   logic [hpf_pkg::VAL_W-1:0]    val_ff, val_in;
   logic                         last_ff, last_in;
   logic                         full_ff, full_in;
   logic [hpf_pkg::PC_W-1:0]     p_ff, p_in;
   logic [hpf_pkg::VAL_W-2:0]    cutoff_ff, cutoff_in;
   logic [hpf_pkg::CNT_W-1:0]    r_ff, r_in;
   logic [hpf_pkg::BIN_W-1:0]    lp_ff, lp_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [hpf_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic                         found_ff, found_in;
   logic [hpf_pkg::TOT_W-1:0]    total_ff, total_in;
   logic                         listfull_ff, listfull_in;
   logic                         rsp_last_ff, rsp_last_in;

   hpf_pkg::div_req_type         div_req;
   hpf_pkg::div_rsp_type         div_rsp;

   logic                         accept;
   logic                         out_free;
   logic [hpf_pkg::VAL_W-1:0]    in_count;
   logic                         match;
   logic                         room;
   logic                         live;
   logic                         new_peak;
   logic                         go_div;
   logic [hpf_pkg::DIV_W-1:0]    divisor_eff;
   logic [hpf_pkg::PL_IDX_W-1:0] pl_idx;
   logic [hpf_pkg::BIN_W-1:0]    loc;
   logic [hpf_pkg::BIN_W-1:0]    rd_addr;
   logic [hpf_pkg::VAL_W-1:0]    rd_data;
   logic                         above;
   logic [hpf_pkg::BIN_W-1:0]    lp_dec;
   logic [hpf_pkg::PC_W-1:0]     p_inc;
   logic [hpf_pkg::CNT_W:0]      span_sum;
   logic [hpf_pkg::PROD_W-1:0]   scaled;
   logic [hpf_pkg::POS_W-1:0]    refined;
   logic [hpf_pkg::PCX_W-1:0]    pc_ext;
   logic [hpf_pkg::TOT_W-1:0]    tot_sat;
   logic                         final_out;

   hpf_ram #(
      .WIDTH (hpf_pkg::VAL_W),
      .DEPTH (hpf_pkg::NUM_BINS)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (accept && match && room),
      .wr_addr (bincnt_ff[hpf_pkg::BIN_W-1:0]),
      .wr_data (in_count),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hpf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == hpf_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign in_count   = req_tdata[hpf_pkg::VAL_W-1:0];
   assign match      = (req_tuser == colour_sel_ff);
   assign room       = (bincnt_ff < hpf_pkg::CNT_W'(hpf_pkg::NUM_BINS));
   assign live       = (pc_ff < hpf_pkg::PC_W'(hpf_pkg::MAX_PEAKS));
   assign new_peak   = (in_count > rp_ff) && (in_count > floor_ff) && (in_count > min_ff);
   assign go_div     = match && room && live && !new_peak && open_ff;
   assign divisor_eff = (divcfg_ff == '0) ? hpf_pkg::DIV_W'(1) : divcfg_ff;
   assign pl_idx     = pc_ff[hpf_pkg::PL_IDX_W-1:0];
   assign loc        = peak_list_ff[p_ff[hpf_pkg::PL_IDX_W-1:0]];
   assign above      = (rd_data > {1'b0, cutoff_ff});
   assign lp_dec     = lp_ff - 1'b1;
   assign p_inc      = p_ff + 1'b1;

   // Center of the span: (right end + left end) / 2, left end kept as lp - 1
   assign span_sum = {1'b0, r_ff} + (hpf_pkg::CNT_W + 1)'(lp_ff)
                     - (hpf_pkg::CNT_W + 1)'(1);
   assign scaled   = hpf_pkg::PROD_W'(span_sum[hpf_pkg::CNT_W:1])
                     * hpf_pkg::PROD_W'(hpf_pkg::BIN_SCALE);
   assign refined  = (scaled > hpf_pkg::PROD_W'(hpf_pkg::POS_MAX)) ?
                     hpf_pkg::POS_W'(hpf_pkg::POS_MAX) : scaled[hpf_pkg::POS_W-1:0];

   assign pc_ext  = hpf_pkg::PCX_W'(pc_ff);
   assign tot_sat = (pc_ext > hpf_pkg::PCX_W'(hpf_pkg::TOT_MAX)) ?
                    hpf_pkg::TOT_W'(hpf_pkg::TOT_MAX) : pc_ext[hpf_pkg::TOT_W-1:0];
   assign final_out = (pc_ff == '0) || (p_inc == pc_ff);

   assign div_req.start    = accept && go_div;
   assign div_req.dividend = rp_ff;
   assign div_req.divisor  = divisor_eff;

   always_comb begin
      state_in      = state_ff;
      colour_sel_in = colour_sel_ff;
      floor_in      = floor_ff;
      divcfg_in     = divcfg_ff;
      rp_in         = rp_ff;
      rpbin_in      = rpbin_ff;
      open_in       = open_ff;
      min_in        = min_ff;
      pc_in         = pc_ff;
      bincnt_in     = bincnt_ff;
      peak_list_in  = peak_list_ff;
      val_in        = val_ff;
      last_in       = last_ff;
      full_in       = full_ff;
      p_in          = p_ff;
      cutoff_in     = cutoff_ff;
      r_in          = r_ff;
      lp_in         = lp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      pos_in        = pos_ff;
      found_in      = found_ff;
      total_in      = total_ff;
      listfull_in   = listfull_ff;
      rsp_last_in   = rsp_last_ff;
      rd_addr       = loc;

      if (csr_wr_en) begin
         unique case (csr_index)
            hpf_pkg::CSR_COLOUR:  colour_sel_in = csr_wr_data[hpf_pkg::COLOUR_W-1:0];
            hpf_pkg::CSR_FLOOR:   floor_in      = csr_wr_data[hpf_pkg::VAL_W-1:0];
            hpf_pkg::CSR_DIVISOR: divcfg_in     = csr_wr_data[hpf_pkg::DIV_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         hpf_pkg::ST_IDLE: begin
            if (accept) begin
               val_in  = in_count;
               last_in = req_tlast;
               if (match && room) begin
                  bincnt_in = bincnt_ff + 1'b1;
                  if (live && new_peak) begin
                     rp_in    = in_count;
                     rpbin_in = bincnt_ff[hpf_pkg::BIN_W-1:0];
                     open_in  = 1'b1;
                  end
               end
               if (go_div) begin
                  state_in = hpf_pkg::ST_DIV;
               end else if (req_tlast) begin
                  state_in = hpf_pkg::ST_FIN;
               end
            end
         end
         hpf_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               // close the peak when the bin drops below its level
               if (val_ff < div_rsp.quotient) begin
                  min_in               = div_rsp.quotient;
                  open_in              = 1'b0;
                  rp_in                = '0;
                  peak_list_in[pl_idx] = rpbin_ff;
                  pc_in                = pc_ff + 1'b1;
               end
               state_in = last_ff ? hpf_pkg::ST_FIN : hpf_pkg::ST_IDLE;
            end
         end
         hpf_pkg::ST_FIN: begin
            full_in = !live;
            if (live && open_ff) begin
               peak_list_in[pl_idx] = rpbin_ff;
               pc_in                = pc_ff + 1'b1;
            end
            p_in     = '0;
            state_in = hpf_pkg::ST_PEAK;
         end
         hpf_pkg::ST_PEAK: begin
            state_in = ((pc_ff == '0) || full_ff) ? hpf_pkg::ST_OUT : hpf_pkg::ST_CUT;
         end
         hpf_pkg::ST_CUT: begin
            cutoff_in = rd_data[hpf_pkg::VAL_W-1:1];
            r_in      = hpf_pkg::CNT_W'(loc) + 1'b1;
            lp_in     = loc;
            state_in  = hpf_pkg::ST_RCHK;
         end
         hpf_pkg::ST_RCHK: begin
            rd_addr  = r_ff[hpf_pkg::BIN_W-1:0];
            state_in = (r_ff < bincnt_ff) ? hpf_pkg::ST_RCMP : hpf_pkg::ST_LCHK;
         end
         hpf_pkg::ST_RCMP: begin
            if (above) begin
               r_in     = r_ff + 1'b1;
               state_in = hpf_pkg::ST_RCHK;
            end else begin
               state_in = hpf_pkg::ST_LCHK;
            end
         end
         hpf_pkg::ST_LCHK: begin
            rd_addr  = lp_dec;
            state_in = (lp_ff != '0) ? hpf_pkg::ST_LCMP : hpf_pkg::ST_OUT;
         end
         hpf_pkg::ST_LCMP: begin
            if (above) begin
               lp_in    = lp_dec;
               state_in = hpf_pkg::ST_LCHK;
            end else begin
               state_in = hpf_pkg::ST_OUT;
            end
         end
         hpf_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pc_ff == '0) begin
                  pos_in = '0;
               end else if (full_ff) begin
                  pos_in = hpf_pkg::POS_W'(loc);
               end else begin
                  pos_in = refined;
               end
               found_in    = (pc_ff != '0);
               total_in    = tot_sat;
               listfull_in = full_ff;
               rsp_last_in = final_out;
               if (final_out) begin
                  // histogram done: drop all tracking state
                  rp_in     = '0;
                  rpbin_in  = '0;
                  open_in   = 1'b0;
                  min_in    = '0;
                  pc_in     = '0;
                  bincnt_in = '0;
                  state_in  = hpf_pkg::ST_IDLE;
               end else begin
                  p_in     = p_inc;
                  state_in = hpf_pkg::ST_PEAK;
               end
            end
         end
         default: state_in = hpf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hpf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colour_sel_ff <= '0;
         floor_ff      <= '0;
         divcfg_ff     <= hpf_pkg::DIVISOR_RESET;
         rp_ff         <= '0;
         rpbin_ff      <= '0;
         open_ff       <= 1'b0;
         min_ff        <= '0;
         pc_ff         <= '0;
         bincnt_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         colour_sel_ff <= colour_sel_in;
         floor_ff      <= floor_in;
         divcfg_ff     <= divcfg_in;
         rp_ff         <= rp_in;
         rpbin_ff      <= rpbin_in;
         open_ff       <= open_in;
         min_ff        <= min_in;
         pc_ff         <= pc_in;
         bincnt_ff     <= bincnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      peak_list_ff <= peak_list_in;
      val_ff       <= val_in;
      last_ff      <= last_in;
      full_ff      <= full_in;
      p_ff         <= p_in;
      cutoff_ff    <= cutoff_in;
      r_ff         <= r_in;
      lp_ff        <= lp_in;
      pos_ff       <= pos_in;
      found_ff     <= found_in;
      total_ff     <= total_in;
      listfull_ff  <= listfull_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(hpf_pkg::RSP_DATA_W - hpf_pkg::POS_W - hpf_pkg::TOT_W)'(0),
                        total_ff, pos_ff};
   assign rsp_tuser  = {listfull_ff, found_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_pc_bound: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= hpf_pkg::PC_W'(hpf_pkg::MAX_PEAKS))
      else $error("peak count beyond list size");

   a_bin_bound: assert property (@(posedge clock) disable iff (reset)
      bincnt_ff <= hpf_pkg::CNT_W'(hpf_pkg::NUM_BINS))
      else $error("bin counter beyond bin memory");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (open_ff && state_ff == hpf_pkg::ST_IDLE))
      else $error("divider started without an open peak");

   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hpf_pkg::ST_RCMP) |-> (r_ff < bincnt_ff))
      else $error("span walk read past loaded bins");

   a_end_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hpf_pkg::ST_OUT && out_free && final_out)
      |=> (pc_ff == '0 && bincnt_ff == '0 && !open_ff && state_ff == hpf_pkg::ST_IDLE))
      else $error("tracking state not cleared after final result");
`endif

endmodule

// File: tb/tb_histogram_peak_finder_unit.sv
`timescale 1ns / 100ps

module tb_histogram_peak_finder_unit;

   localparam int RANDOM_ITEMS = 200;
   localparam int LAST_PHASE   = 4;
   localparam int LONG_HOLD    = 400;
   localparam int SETTLE       = 40;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_MAX   = 10;

   typedef enum int { MODE_BUMPS, MODE_ZIGZAG, MODE_NOISE } hist_mode_type;

   typedef struct packed {
      logic [hpf_pkg::POS_W-1:0] position;
      logic                      found;
      logic [hpf_pkg::TOT_W-1:0] total;
      logic                      full;
      logic                      last;
   } peak_result_type;

   // Tracks the peak search of one histogram and holds the peaks it predicts.
   class peak_tracker_type;
      logic [hpf_pkg::COLOUR_W-1:0] cfg_colour;
      logic [hpf_pkg::VAL_W-1:0]    cfg_floor;
      logic [hpf_pkg::DIV_W-1:0]    cfg_divisor;

      logic [hpf_pkg::VAL_W-1:0]    bin_mem [hpf_pkg::NUM_BINS];
      int                           peak_bins [hpf_pkg::MAX_PEAKS];
      int                           top_value;
      int                           top_bin;
      bit                           open;
      int                           min_level;
      int                           n_peaks;
      int                           n_loaded;

      peak_result_type              pending_peaks [$];
      int                           expected_total;
      int                           failures;

      function new();
         cfg_colour     = '0;
         cfg_floor      = '0;
         cfg_divisor    = hpf_pkg::DIVISOR_RESET;
         expected_total = 0;
         failures       = 0;
         clear();
      endfunction

      function void clear();
         top_value = 0;
         top_bin   = 0;
         open      = 1'b0;
         min_level = 0;
         n_peaks   = 0;
         n_loaded  = 0;
      endfunction

      function void write_reg(logic [hpf_pkg::CSR_IDX_W-1:0] idx,
                              logic [hpf_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            hpf_pkg::CSR_COLOUR:  cfg_colour  = data[hpf_pkg::COLOUR_W-1:0];
            hpf_pkg::CSR_FLOOR:   cfg_floor   = data[hpf_pkg::VAL_W-1:0];
            hpf_pkg::CSR_DIVISOR: cfg_divisor = data[hpf_pkg::DIV_W-1:0];
            default: ;
         endcase
      endfunction

      // Append one predicted peak to the tail of the queue.
      function void queue_peak(peak_result_type item);
         pending_peaks = {pending_peaks, item};
         expected_total++;
      endfunction

      // Center of the span above half the peak height, in pixels.
      function int centre_of(int loc);
         int cutoff;
         int r;
         int l;
         int pos;
         cutoff = bin_mem[loc] >> 1;
         r = loc + 1;
         l = loc - 1;
         while (r < n_loaded && bin_mem[r] > cutoff) r++;
         while (l >= 0 && bin_mem[l] > cutoff) l--;
         pos = ((r + l) >> 1) * hpf_pkg::BIN_SCALE;
         return (pos > hpf_pkg::POS_MAX) ? hpf_pkg::POS_MAX : pos;
      endfunction

      function void take_bin(logic [hpf_pkg::COLOUR_W-1:0] colour,
                             logic [hpf_pkg::VAL_W-1:0] count, bit last);
         int div;
         int val;
         bit full;
         peak_result_type item;
         val = count;
         div = (cfg_divisor == 0) ? 1 : cfg_divisor;
         if (colour == cfg_colour && n_loaded < hpf_pkg::NUM_BINS) begin
            bin_mem[n_loaded] = count;
            if (n_peaks < hpf_pkg::MAX_PEAKS) begin
               if (val > top_value && val > cfg_floor && val > min_level) begin
                  top_value = val;
                  top_bin   = n_loaded;
                  open      = 1'b1;
               end else if (open && val < top_value / div) begin
                  min_level = top_value / div;
                  open      = 1'b0;
                  top_value = 0;
                  peak_bins[n_peaks] = top_bin;
                  n_peaks++;
               end
            end
            n_loaded++;
         end
         if (!last) return;

         full = (n_peaks >= hpf_pkg::MAX_PEAKS);
         if (!full && open) begin
            peak_bins[n_peaks] = top_bin;
            n_peaks++;
         end
         if (n_peaks == 0) begin
            item = '{position: '0, found: 1'b0, total: '0, full: 1'b0, last: 1'b1};
            queue_peak(item);
         end
         for (int p = 0; p < n_peaks; p++) begin
            item.position = full ? hpf_pkg::POS_W'(peak_bins[p])
                                 : hpf_pkg::POS_W'(centre_of(peak_bins[p]));
            item.found    = 1'b1;
            item.total    = (n_peaks > hpf_pkg::TOT_MAX) ? hpf_pkg::TOT_W'(hpf_pkg::TOT_MAX)
                                                         : hpf_pkg::TOT_W'(n_peaks);
            item.full     = full;
            item.last     = (p + 1 == n_peaks);
            queue_peak(item);
         end
         clear();
      endfunction

      function void check_peak(peak_result_type seen);
         peak_result_type want;
         if (pending_peaks.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("unexpected peak: pos=%0d found=%0b total=%0d full=%0b last=%0b",
                        seen.position, seen.found, seen.total, seen.full, seen.last);
            return;
         end
         want = pending_peaks.pop_front();
         if (seen !== want) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("peak mismatch: expected pos=%0d found=%0b total=%0d %s%s",
                        want.position, want.found, want.total,
                        $sformatf("full=%0b last=%0b, ", want.full, want.last),
                        $sformatf("got pos=%0d found=%0b total=%0d full=%0b last=%0b",
                                  seen.position, seen.found, seen.total, seen.full,
                                  seen.last));
         end
      endfunction

      function void finish_check();
         if (pending_peaks.size() != 0) begin
            failures += pending_peaks.size();
            $display("%0d expected peaks never arrived", pending_peaks.size());
         end
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [hpf_pkg::REQ_DATA_W-1:0] req_tdata;   // bin_count
   logic [hpf_pkg::COLOUR_W-1:0]   req_tuser;   // bin_colour
   logic                           req_tlast;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [hpf_pkg::RSP_DATA_W-1:0] rsp_tdata;   // peak_position, peak_total
   logic [hpf_pkg::RSP_USER_W-1:0] rsp_tuser;   // peak_found, list_full
   logic                           rsp_tlast;
   logic                           csr_wr_en;
   logic [hpf_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [hpf_pkg::CSR_DATA_W-1:0] csr_wr_data;

   peak_tracker_type               tracker = new();
   logic [hpf_pkg::COLOUR_W-1:0]   cur_colour;
   bit                             no_gaps;
   int                             random_items;
   int                             hold_requests;
   int                             hold_served;
   int                             cycle_count;

   histogram_peak_finder_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Result side: check each transfer, then pick the next ready level.
   initial begin
      int hold_left;
      int calm_left;
      int r;
      peak_result_type seen;
      hold_left   = 0;
      calm_left   = 0;
      hold_served = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            seen.position = rsp_tdata[hpf_pkg::POS_W-1:0];
            seen.total    = rsp_tdata[hpf_pkg::POS_W+hpf_pkg::TOT_W-1:hpf_pkg::POS_W];
            seen.found    = rsp_tuser[0];
            seen.full     = rsp_tuser[1];
            seen.last     = rsp_tlast;
            tracker.check_peak(seen);
         end
         if (hold_requests != hold_served) begin
            hold_served++;
            hold_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               calm_left = $urandom_range(50, 200);
               rsp_tready <= 1'b1;
            end else if (r < 25) begin
               hold_left = $urandom_range(0, 2);
               rsp_tready <= 1'b0;
            end else if (r < 29) begin
               hold_left = $urandom_range(10, 40);
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   task automatic send_bin(input logic [hpf_pkg::COLOUR_W-1:0] colour,
                           input logic [hpf_pkg::VAL_W-1:0] count, input bit last);
      int r;
      int gap;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 30);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= colour;
      req_tdata  <= hpf_pkg::REQ_DATA_W'(count);
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      tracker.take_bin(colour, count, last);
   endtask

   task automatic send_histogram(input int len, input hist_mode_type mode);
      int level;
      bit rising;
      int step;
      logic [hpf_pkg::VAL_W-1:0] count;
      logic [hpf_pkg::COLOUR_W-1:0] colour;
      level  = $urandom_range(0, 300);
      rising = 1'b1;
      for (int i = 0; i < len; i++) begin
         case (mode)
            MODE_NOISE:  count = hpf_pkg::VAL_W'($urandom_range(0, 1023));
            MODE_ZIGZAG: count = (i % 2 == 0) ? hpf_pkg::VAL_W'($urandom_range(600, 1023))
                                              : hpf_pkg::VAL_W'($urandom_range(0, 50));
            default: begin
               step = $urandom_range(0, 350);
               level = rising ? level + step : level - step;
               if (level >= 1023) begin
                  level  = 1023;
                  rising = 1'b0;
               end else if (level <= 0) begin
                  level  = 0;
                  rising = 1'b1;
               end else if ($urandom_range(0, 9) < 3) begin
                  rising = !rising;
               end
               count = hpf_pkg::VAL_W'(level);
            end
         endcase
         colour = ($urandom_range(0, 99) < 85) ? cur_colour
                                               : hpf_pkg::COLOUR_W'($urandom_range(0, 15));
         send_bin(colour, count, i == len - 1);
      end
      random_items += len;
   endtask

   task automatic write_csr(input logic [hpf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [hpf_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      tracker.write_reg(idx, data);
   endtask

   task automatic set_config(input logic [hpf_pkg::COLOUR_W-1:0] colour,
                             input logic [hpf_pkg::VAL_W-1:0] floor_v,
                             input logic [hpf_pkg::DIV_W-1:0] divisor);
      write_csr(hpf_pkg::CSR_COLOUR, hpf_pkg::CSR_DATA_W'(colour));
      write_csr(hpf_pkg::CSR_FLOOR, hpf_pkg::CSR_DATA_W'(floor_v));
      write_csr(hpf_pkg::CSR_DIVISOR, hpf_pkg::CSR_DATA_W'(divisor));
      csr_wr_en  <= 1'b0;
      cur_colour  = colour;
   endtask

   // Hold the input until every peak is out, then let a bin compare finish.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.pending_peaks.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      logic [hpf_pkg::COLOUR_W-1:0] c;
      logic [hpf_pkg::VAL_W-1:0] f;
      logic [hpf_pkg::DIV_W-1:0] d;
      hist_mode_type mode;
      int phase;
      int n_hist;
      int len;
      int r;
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      req_tuser     <= '0;
      req_tlast     <= 1'b0;
      csr_wr_en     <= 1'b0;
      csr_index     <= hpf_pkg::CSR_COLOUR;
      csr_wr_data   <= '0;
      cur_colour     = '0;
      no_gaps        = 1'b0;
      random_items   = 0;
      hold_requests  = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings. A lone empty bin: no peaks.
      send_bin(4'd0, 10'd0, 1'b1);
      // Close a peak, skip other colours, end on a foreign bin with a peak open.
      send_bin(4'd0, 10'd1023, 1'b0);
      send_bin(4'd0, 10'd0, 1'b0);
      send_bin(4'd7, 10'd800, 1'b0);
      send_bin(4'd0, 10'd600, 1'b0);
      send_bin(4'd0, 10'd1023, 1'b0);
      send_bin(4'd0, 10'd512, 1'b0);
      send_bin(4'd15, 10'd1000, 1'b1);
      // Alternate full and empty bins until the peak list fills.
      for (int k = 0; k < 13; k++)
         send_bin(4'd0, (k % 2 == 0) ? 10'd1023 : 10'd0, k == 12);
      drain();

      phase = 0;
      while (random_items < RANDOM_ITEMS || phase <= LAST_PHASE) begin
         case (phase)
            0: begin c = 4'd15; f = 10'd1023; d = 5'd16; end
            1: begin c = 4'd3;  f = 10'd0;    d = 5'd0;  end
            2: begin c = 4'd0;  f = 10'd0;    d = 5'd1;  end
            3: begin c = hpf_pkg::COLOUR_W'($urandom_range(0, 15)); f = 10'd0; d = 5'd2; end
            default: begin
               c = hpf_pkg::COLOUR_W'($urandom_range(0, 15));
               r = $urandom_range(0, 9);
               f = (r < 2) ? 10'd0 : (r < 3) ? 10'd1023
                 : (r < 4) ? hpf_pkg::VAL_W'($urandom_range(0, 1023))
                           : hpf_pkg::VAL_W'($urandom_range(0, 300));
               r = $urandom_range(0, 19);
               d = (r < 2) ? 5'd0 : (r < 4) ? 5'd1 : (r < 6) ? 5'd16 : (r < 7) ? 5'd31
                 : hpf_pkg::DIV_W'($urandom_range(1, 16));
            end
         endcase
         set_config(c, f, d);
         no_gaps = ($urandom_range(0, 3) == 0);
         n_hist  = $urandom_range(1, 2);
         if (phase == LAST_PHASE) begin
            // Stall the result side for a long stretch while bins keep coming.
            no_gaps = 1'b1;
            n_hist  = 4;
            hold_requests++;
         end
         for (int h = 0; h < n_hist; h++) begin
            len = (phase == 3 && h == 0) ? hpf_pkg::NUM_BINS + 4 : $urandom_range(2, 16);
            r = $urandom_range(0, 9);
            mode = (r < 6) ? MODE_BUMPS : (r < 8) ? MODE_ZIGZAG : MODE_NOISE;
            send_histogram(len, mode);
         end
         drain();
         phase++;
      end

      repeat (100) @(posedge clock);
      tracker.finish_check();
      if (tracker.failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/hpf_pkg.sv
hw/rtl/hpf_ram.sv
hw/rtl/hpf_div.sv
hw/rtl/histogram_peak_finder_unit.sv
tb/tb_histogram_peak_finder_unit.sv
